// File: rtl/pdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared sizes, command and status codes and entry type of the positional
// deque buffer.
// ----------------------------------------------------------------------------
package pdb_pkg;

  // Built storage
  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Field widths
  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 5;
  localparam int SIZE_BITS   = 8;
  localparam int STATUS_BITS = 3;
  localparam int CAP_BITS    = 5;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_EXT_FRONT = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_EXT_BACK  = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_EXT_AT    = 3'd5;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STS_OK    = 3'd0;
  localparam logic [STATUS_BITS-1:0] STS_FULL  = 3'd1;
  localparam logic [STATUS_BITS-1:0] STS_EMPTY = 3'd2;
  localparam logic [STATUS_BITS-1:0] STS_RANGE = 3'd3;
  localparam logic [STATUS_BITS-1:0] STS_ZERO  = 3'd4;

  // Capacity after reset
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(DEPTH);

  // One stored entry
  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/positional_deque_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_deque_buffer
// Ordered buffer of tagged entries with insert and extract at the front, the
// back or a logical position, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Entries sit in logical order in a single-port-read, single-port-write RAM,
// front at address 0. A positional insert or extract moves the entries behind
// the position one RAM slot per cycle (read one, write the neighbor, overlapped);
// the single RAM port and its registered read set this rate. An append at the
// back moves no entries and only writes the new one. Rejected or unused
// commands give their result the cycle after acceptance and can follow back to
// back. The result sits in an output register, so a new transaction is taken
// in the same cycle a waiting result is taken. Capacity is written through the
// configuration channel while idle; 0 acts as 1.
// ----------------------------------------------------------------------------
module positional_deque_buffer (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [pdb_pkg::CAP_BITS-1:0]         cfg_data,
  // command channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [pdb_pkg::CMD_BITS-1:0]         command,
  input  wire  [pdb_pkg::POS_BITS-1:0]         position,
  input  wire  [pdb_pkg::DATA_BITS-1:0]        entry_data,
  input  wire  [pdb_pkg::SIZE_BITS-1:0]        entry_size,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [pdb_pkg::DATA_BITS-1:0]        taken_data,
  output logic [pdb_pkg::SIZE_BITS-1:0]        taken_size,
  output logic [pdb_pkg::STATUS_BITS-1:0]      status,
  output logic [pdb_pkg::CNT_BITS-1:0]         occupancy,
  output logic                                 is_empty,
  output logic                                 is_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_EXT  = 2'd2;

  localparam logic [pdb_pkg::CNT_BITS-1:0] CNT_DEPTH = pdb_pkg::CNT_BITS'(pdb_pkg::DEPTH);
  localparam logic [pdb_pkg::CNT_BITS-1:0] CNT_ONE   = pdb_pkg::CNT_BITS'(1);

  // Control state
  logic [1:0]                       state;
  logic [pdb_pkg::CNT_BITS-1:0]     count;
  logic [pdb_pkg::CAP_BITS-1:0]     cap;
  logic [pdb_pkg::CNT_BITS-1:0]     left;
  logic                             wr_pend;
  logic                             take_pend;
  logic                             first_rd;
  logic [pdb_pkg::ADDR_BITS-1:0]    rd_addr;
  logic [pdb_pkg::ADDR_BITS-1:0]    wr_addr;
  logic [pdb_pkg::ADDR_BITS-1:0]    ins_pos;
  pdb_pkg::entry_t                  ins_entry;

  // RAM
  pdb_pkg::entry_t                  mem [pdb_pkg::DEPTH];
  pdb_pkg::entry_t                  q;
  logic                             mem_re;
  logic                             mem_we;
  logic [pdb_pkg::ADDR_BITS-1:0]    mem_waddr;
  pdb_pkg::entry_t                  mem_wdata;

  // Decode
  logic                             in_fire;
  logic                             is_ins;
  logic                             is_ext;
  logic                             full_now;
  logic [pdb_pkg::CNT_BITS-1:0]     eff_cap;
  logic [pdb_pkg::CNT_BITS-1:0]     ins_p;
  logic [pdb_pkg::CNT_BITS-1:0]     ext_p;
  logic [pdb_pkg::STATUS_BITS-1:0]  chk_status;
  logic                             shift_done;
  logic [pdb_pkg::CNT_BITS-1:0]     count_done;
  logic                             result_set;

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;

  // Effective capacity: 0 acts as 1, above the built depth acts as the depth
  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_ONE;
    end else if (pdb_pkg::CNT_BITS'(cap) > CNT_DEPTH) begin
      eff_cap = CNT_DEPTH;
    end else begin
      eff_cap = pdb_pkg::CNT_BITS'(cap);
    end
  end

  assign full_now = (count >= eff_cap) || (count >= CNT_DEPTH);

  // Command checks and target position
  always_comb begin
    is_ins     = 1'b0;
    is_ext     = 1'b0;
    ins_p      = '0;
    ext_p      = '0;
    chk_status = pdb_pkg::STS_OK;
    unique case (command)
      pdb_pkg::CMD_INS_FRONT, pdb_pkg::CMD_INS_BACK, pdb_pkg::CMD_INS_AT: begin
        if (command == pdb_pkg::CMD_INS_BACK) begin
          ins_p = count;
        end else if (command == pdb_pkg::CMD_INS_AT) begin
          ins_p = (pdb_pkg::CNT_BITS'(position) > count) ? count
                                                         : pdb_pkg::CNT_BITS'(position);
        end
        if (full_now) begin
          chk_status = pdb_pkg::STS_FULL;
        end else if (entry_size == '0) begin
          chk_status = pdb_pkg::STS_ZERO;
        end else begin
          is_ins = 1'b1;
        end
      end
      pdb_pkg::CMD_EXT_FRONT, pdb_pkg::CMD_EXT_BACK, pdb_pkg::CMD_EXT_AT: begin
        if (command == pdb_pkg::CMD_EXT_BACK) begin
          ext_p = count - CNT_ONE;
        end else if (command == pdb_pkg::CMD_EXT_AT) begin
          ext_p = pdb_pkg::CNT_BITS'(position);
        end
        if (count == '0) begin
          chk_status = pdb_pkg::STS_EMPTY;
        end else if (ext_p >= count) begin
          chk_status = pdb_pkg::STS_RANGE;
        end else begin
          is_ext = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM port control
  assign mem_re     = (state != ST_IDLE) && (left != '0);
  assign shift_done = (state != ST_IDLE) && (left == '0) && !wr_pend;
  assign count_done = (state == ST_INS) ? count + CNT_ONE : count - CNT_ONE;

  // A result is ready after a reject, an unused command or a finished shift
  assign result_set = (in_fire && !is_ins && !is_ext) || shift_done;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = q;
    if (state == ST_INS) begin
      if (wr_pend) begin
        mem_we = 1'b1;
      end else if (left == '0) begin
        mem_we    = 1'b1;
        mem_waddr = ins_pos;
        mem_wdata = ins_entry;
      end
    end else if (state == ST_EXT) begin
      mem_we = wr_pend && !take_pend;
    end
  end

  // RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      q <= mem[rd_addr];
    end
  end

  // Sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap       <= pdb_pkg::CAP_RESET;
      left      <= '0;
      wr_pend   <= 1'b0;
      take_pend <= 1'b0;
      first_rd  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (result_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_ins) begin
              state    <= ST_INS;
              left     <= count - ins_p;
              rd_addr  <= pdb_pkg::ADDR_BITS'(count - CNT_ONE);
              ins_pos  <= pdb_pkg::ADDR_BITS'(ins_p);
            end else if (is_ext) begin
              state    <= ST_EXT;
              left     <= count - ext_p;
              rd_addr  <= pdb_pkg::ADDR_BITS'(ext_p);
              first_rd <= 1'b1;
            end
          end
        end
        ST_INS, ST_EXT: begin
          wr_pend   <= mem_re;
          take_pend <= mem_re && first_rd;
          if (mem_re) begin
            left     <= left - CNT_ONE;
            first_rd <= 1'b0;
            if (state == ST_INS) begin
              wr_addr <= rd_addr + 1'b1;
              rd_addr <= rd_addr - 1'b1;
            end else begin
              wr_addr <= rd_addr - 1'b1;
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (shift_done) begin
            state     <= ST_IDLE;
            count     <= count_done;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload and captured insert entry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ins_entry.data <= entry_data;
      ins_entry.size <= entry_size;
      taken_data     <= '0;
      taken_size     <= '0;
      status         <= chk_status;
      occupancy      <= count;
      is_empty       <= (count == '0);
      is_full        <= (count >= eff_cap);
    end
    if (state == ST_EXT && take_pend) begin
      taken_data <= q.data;
      taken_size <= q.size;
    end
    if (shift_done) begin
      status    <= pdb_pkg::STS_OK;
      occupancy <= count_done;
      is_empty  <= (count_done == '0);
      is_full   <= (count_done >= eff_cap);
    end
  end

  // Checks
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result shown while a shift is running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_DEPTH)
    else $error("entry count above built depth");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS) |-> (count < CNT_DEPTH))
    else $error("insert running on a full buffer");

  a_ext_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXT) |-> (count != '0))
    else $error("extract running on an empty buffer");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    shift_done |=> (out_valid && (status == pdb_pkg::STS_OK)))
    else $error("finished shift gave no ok result");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional deque buffer. A shadow copy of the
// buffer predicts every result as commands are accepted. A sink process
// compares the results field by field. Directed tests cover empty, full,
// range and zero-size rejects and the capacity corners. Random traffic then
// sweeps the occupancy between empty and full under several capacities.
// ----------------------------------------------------------------------------
module tb_top;
  import pdb_pkg::*;

  // Unused command codes; the block must ignore them
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 245;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = DEPTH + 8;

  typedef struct {
    logic [DATA_BITS-1:0]   data;
    logic [SIZE_BITS-1:0]   size;
    logic [STATUS_BITS-1:0] status;
    logic [CNT_BITS-1:0]    count;
    logic                   empty;
    logic                   full;
  } result_t;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CAP_BITS-1:0]    cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [CMD_BITS-1:0]    command    = CMD_INS_FRONT;
  logic [POS_BITS-1:0]    position   = '0;
  logic [DATA_BITS-1:0]   entry_data = '0;
  logic [SIZE_BITS-1:0]   entry_size = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [DATA_BITS-1:0]   taken_data;
  logic [SIZE_BITS-1:0]   taken_size;
  logic [STATUS_BITS-1:0] status;
  logic [CNT_BITS-1:0]    occupancy;
  logic                   is_empty;
  logic                   is_full;

  // Shadow of the buffer contents and the capacity register
  entry_t              held_entries[$];
  logic [CAP_BITS-1:0] cap_reg = CAP_RESET;
  result_t             pending_results[$];
  int unsigned         error_count  = 0;
  int unsigned         quiet_cycles = 0;
  bit                  idle_on      = 1'b1;

  positional_deque_buffer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .position   (position),
    .entry_data (entry_data),
    .entry_size (entry_size),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .taken_data (taken_data),
    .taken_size (taken_size),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Capacity as the block applies it: 0 acts as 1, above DEPTH acts as DEPTH
  function automatic int unsigned cap_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  // Update the shadow buffer for one command and return its result
  function automatic result_t apply_command(logic [CMD_BITS-1:0] cmd,
                                            logic [POS_BITS-1:0] pos,
                                            logic [DATA_BITS-1:0] data,
                                            logic [SIZE_BITS-1:0] size);
    result_t     r;
    entry_t      e;
    int unsigned n;
    int unsigned slot;
    r = '{default: '0};
    r.status = STS_OK;
    n = held_entries.size();
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        // full wins over zero size
        if (n >= cap_limit()) begin
          r.status = STS_FULL;
        end else if (size == '0) begin
          r.status = STS_ZERO;
        end else begin
          if (cmd == CMD_INS_FRONT) slot = 0;
          else if (cmd == CMD_INS_BACK || pos > n) slot = n;
          else slot = pos;
          e.data = data;
          e.size = size;
          held_entries.insert(slot, e);
        end
      end
      CMD_EXT_FRONT, CMD_EXT_BACK, CMD_EXT_AT: begin
        if (n == 0) begin
          r.status = STS_EMPTY;
        end else begin
          if (cmd == CMD_EXT_FRONT) slot = 0;
          else if (cmd == CMD_EXT_BACK) slot = n - 1;
          else slot = pos;
          if (slot >= n) begin
            r.status = STS_RANGE;
          end else begin
            r.data = held_entries[slot].data;
            r.size = held_entries[slot].size;
            held_entries.delete(slot);
          end
        end
      end
      default: ;
    endcase
    n = held_entries.size();
    r.count = CNT_BITS'(n);
    r.empty = (n == 0);
    r.full  = (n >= cap_limit());
    return r;
  endfunction

  // Send one command transaction and record its predicted result
  task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [POS_BITS-1:0] pos,
                           logic [DATA_BITS-1:0] data, logic [SIZE_BITS-1:0] size);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command    <= cmd;
    position   <= pos;
    entry_data <= data;
    entry_size <= size;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_command(cmd, pos, data, size));
  endtask

  // Let every outstanding result arrive; always waits on the clock, even with none outstanding
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    wait_results_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = value;
  endtask

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endtask

  // Result sink: random stalls while idle_on is set, then compare with the oldest prediction
  initial begin : result_sink
    int unsigned hold;
    result_t     want;
    wait (rst == 1'b0);
    forever begin
      hold = idle_on ? $urandom_range(0, 5) : 0;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result transaction with no command outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("taken_data", want.data, taken_data);
        check_field("taken_size", want.size, taken_size);
        check_field("status", want.status, status);
        check_field("occupancy", want.count, occupancy);
        check_field("is_empty", want.empty, is_empty);
        check_field("is_full", want.full, is_full);
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Rejects on an empty buffer, spare commands, zero-size insert
  task automatic test_empty_and_rejects();
    send_item(CMD_EXT_FRONT, '0, '0, '0);
    send_item(CMD_EXT_BACK, '0, '0, '0);
    send_item(CMD_EXT_AT, '1, '0, '0);
    send_item(CMD_SPARE_LO, '1, '1, '1);
    send_item(CMD_SPARE_HI, '0, '0, '0);
    send_item(CMD_INS_BACK, '0, '1, '0);
  endtask

  // Inserts and extracts at both ends and in the middle, append past the end
  task automatic test_positional_moves();
    send_item(CMD_INS_FRONT, '0, '1, 8'hFF);
    send_item(CMD_INS_BACK, '0, '0, 8'h01);
    send_item(CMD_INS_AT, POS_BITS'(1), 32'h5A5A_A5A5, 8'h80);
    send_item(CMD_INS_AT, '1, 32'hA5A5_5A5A, 8'h7F);
    send_item(CMD_EXT_AT, POS_BITS'(4), '0, '0);
    send_item(CMD_EXT_AT, POS_BITS'(1), '0, '0);
    send_item(CMD_EXT_BACK, '0, '0, '0);
    send_item(CMD_EXT_FRONT, '0, '0, '0);
  endtask

  // Capacity corners, including lowering it below the entries held
  task automatic test_capacity_limits();
    write_capacity('0);
    send_item(CMD_INS_FRONT, '0, 32'h1234_5678, 8'h11);
    send_item(CMD_INS_BACK, '0, 32'h0F0F_0F0F, '0);
    write_capacity(CAP_BITS'(2));
    send_item(CMD_INS_BACK, '0, 32'hDEAD_BEEF, 8'h22);
    write_capacity(CAP_BITS'(1));
    send_item(CMD_INS_AT, '0, 32'h0000_0001, 8'h33);
    send_item(CMD_EXT_AT, '0, '0, '0);
    send_item(CMD_EXT_BACK, '0, '0, '0);
    send_item(CMD_EXT_FRONT, '0, '0, '0);
    write_capacity('1);
  endtask

  task automatic send_random_item(bit filling);
    int unsigned         roll;
    int unsigned         n;
    logic [CMD_BITS-1:0] cmd;
    logic [POS_BITS-1:0] pos;
    logic [DATA_BITS-1:0] data;
    logic [SIZE_BITS-1:0] size;
    n = held_entries.size();
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (roll < (filling ? 80 : 23)) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_INS_FRONT;
        1:       cmd = CMD_INS_BACK;
        default: cmd = CMD_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_EXT_FRONT;
        1:       cmd = CMD_EXT_BACK;
        default: cmd = CMD_EXT_AT;
      endcase
    end
    // mostly near the live range, sometimes anywhere in the field
    if ($urandom_range(0, 9) == 0) pos = POS_BITS'($urandom_range(0, 31));
    else pos = POS_BITS'($urandom_range(0, n + 1));
    case ($urandom_range(0, 19))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom;
    endcase
    case ($urandom_range(0, 19))
      0:       size = '0;
      1:       size = '1;
      default: size = SIZE_BITS'($urandom_range(1, 255));
    endcase
    send_item(cmd, pos, data, size);
  endtask

  // Random traffic swinging between empty and full under several capacities
  task automatic test_random_traffic();
    logic [CAP_BITS-1:0] caps[8];
    bit                  filling;
    caps[0] = CAP_BITS'(16);
    caps[1] = CAP_BITS'(3);
    caps[2] = '1;
    caps[3] = CAP_BITS'(1);
    caps[4] = '0;
    caps[5] = CAP_BITS'(17);
    caps[6] = CAP_BITS'(8);
    caps[7] = CAP_BITS'($urandom_range(0, 31));
    filling = 1'b1;
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      idle_on = (p % 3 != 2);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (held_entries.size() >= cap_limit()) filling = 1'b0;
        else if (held_entries.size() == 0) filling = 1'b1;
        send_random_item(filling);
      end
    end
    idle_on = 1'b1;
  endtask

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_rejects();
    test_positional_moves();
    test_capacity_limits();
    test_random_traffic();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
